// File: rtl/core/tngf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tngf_pkg - shared types and constants for the triangle tangent frame unit
// Widths of the vertex deltas, the multiplier operands, the divider and the
// sequencer state encodings.
// ----------------------------------------------------------------------------
package tngf_pkg;

	// fraction bits of the UV coordinates; the position format cancels out
	localparam int UV_FRAC_BITS = 16;
	localparam int UV_SHIFT     = (UV_FRAC_BITS > 16) ? 16 : UV_FRAC_BITS;

	localparam int POS_W  = 32;
	localparam int UV_W   = 16;
	localparam int DP_W   = POS_W + 1;           // position delta
	localparam int DUV_W  = UV_W + 1;            // UV delta
	localparam int PROD_W = DP_W + DUV_W;        // one product
	localparam int NUM_W  = PROD_W + 1;          // difference of two products
	localparam int DEN_W  = 2 * DUV_W;           // UV determinant
	localparam int QUO_W  = 32;
	localparam int X_W    = NUM_W + 16;          // scaled dividend, worst case

	localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

	localparam logic [2:0] NUM_COMP = 3'd6;      // tangent xyz, bitangent xyz

	typedef enum logic [2:0] {
		T_IDLE,
		T_MAC,
		T_EVAL,
		T_DIV,
		T_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_CHK,
		D_RUN,
		D_FIN
	} div_state_t;

	typedef struct packed {
		logic issue;   // a product enters the multiplier this cycle
		logic sub;     // subtract it from the accumulator instead of loading
	} mac_ctl_t;

	typedef struct packed {
		logic done;    // quotient valid, one cycle
		logic busy;
	} div_sts_t;

endpackage

// File: rtl/core/tngf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tngf_vtx_if / tngf_res_if - valid/ready channels of the tangent frame unit
// One vertex word in, one tangent/bitangent word out.
// ----------------------------------------------------------------------------
interface tngf_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [15:0]        tex_u;
	logic [15:0]        tex_v;
	logic               end_of_mesh;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, end_of_mesh,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, end_of_mesh,
		output ready);
endinterface

interface tngf_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] tangent_x;
	logic signed [31:0] tangent_y;
	logic signed [31:0] tangent_z;
	logic signed [31:0] bitangent_x;
	logic signed [31:0] bitangent_y;
	logic signed [31:0] bitangent_z;
	logic               degenerate;

	modport source (output valid, tangent_x, tangent_y, tangent_z,
		bitangent_x, bitangent_y, bitangent_z, degenerate, input ready);
	modport sink (input valid, tangent_x, tangent_y, tangent_z,
		bitangent_x, bitangent_y, bitangent_z, degenerate, output ready);
endinterface

// File: rtl/core/tngf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tngf_mac - shared multiply / accumulate unit
// Registered product, then load or subtract into the accumulator.
// ----------------------------------------------------------------------------
module tngf_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tngf_pkg::mac_ctl_t                  ctl,
	input  logic signed [tngf_pkg::DP_W-1:0]    a,
	input  logic signed [tngf_pkg::DUV_W-1:0]   b,
	output logic signed [tngf_pkg::NUM_W-1:0]   acc
);

	logic                                 vld_s1;
	logic                                 sub_s1;
	logic signed [tngf_pkg::PROD_W-1:0]   prod_s1;
	logic signed [tngf_pkg::NUM_W-1:0]    acc_q;

	// track which stage holds a product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			sub_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			sub_s1 <= ctl.sub;
		end
	end

	// multiply, then load or subtract
	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= a * b;
		end
		if (vld_s1) begin
			acc_q <= sub_s1 ? acc_q - tngf_pkg::NUM_W'(prod_s1)
				: tngf_pkg::NUM_W'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

// File: rtl/core/tngf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tngf_div - serial scaled divider with saturation
// Gives trunc(num * 2^UV_SHIFT / den) clamped to 32 signed bits, one
// quotient bit per cycle after a single range check.
// ----------------------------------------------------------------------------
module tngf_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [tngf_pkg::NUM_W-1:0]   num,
	input  logic signed [tngf_pkg::DEN_W-1:0]   den,
	output tngf_pkg::div_sts_t                  sts,
	output logic [tngf_pkg::QUO_W-1:0]          quo
);

	localparam int NW = tngf_pkg::NUM_W;
	localparam int DW = tngf_pkg::DEN_W;
	localparam int QW = tngf_pkg::QUO_W;
	localparam int XW = tngf_pkg::X_W;

	tngf_pkg::div_state_t st_q, st_d;

	logic            neg_q;
	logic            ovf_q;
	logic [NW-1:0]   an_q;
	logic [DW-1:0]   ad_q;
	logic [DW-1:0]   rem_q;
	logic [QW-1:0]   xl_q;
	logic [QW-1:0]   qm_q;
	logic [4:0]      cnt_q;
	logic            done_q;
	logic [QW-1:0]   quo_q;

	logic [XW-1:0]   x_c;
	logic            ovf_c;
	logic [DW:0]     r2_c;
	logic            ge_c;
	logic [QW-1:0]   res_c;

	// scaled dividend and range check
	assign x_c   = XW'(an_q) << tngf_pkg::UV_SHIFT;
	assign ovf_c = x_c >= XW'({ad_q, {QW{1'b0}}});

	// one restoring step
	assign r2_c = {rem_q, xl_q[QW-1]};
	assign ge_c = r2_c >= {1'b0, ad_q};

	// apply sign and clamp
	always_comb begin
		if (ovf_q) begin
			res_c = neg_q ? tngf_pkg::SAT_NEG : tngf_pkg::SAT_POS;
		end else if (neg_q) begin
			res_c = (qm_q > tngf_pkg::SAT_NEG) ? tngf_pkg::SAT_NEG : QW'(-qm_q);
		end else begin
			res_c = qm_q[QW-1] ? tngf_pkg::SAT_POS : qm_q;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			tngf_pkg::D_IDLE: if (start) st_d = tngf_pkg::D_CHK;
			tngf_pkg::D_CHK:  st_d = ovf_c ? tngf_pkg::D_FIN : tngf_pkg::D_RUN;
			tngf_pkg::D_RUN:  if (cnt_q == 5'd0) st_d = tngf_pkg::D_FIN;
			tngf_pkg::D_FIN:  st_d = tngf_pkg::D_IDLE;
			default:          st_d = tngf_pkg::D_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= tngf_pkg::D_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == tngf_pkg::D_FIN);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			tngf_pkg::D_IDLE: begin
				if (start) begin
					an_q  <= num[NW-1] ? NW'(-num) : NW'(num);
					ad_q  <= den[DW-1] ? DW'(-den) : DW'(den);
					neg_q <= num[NW-1] ^ den[DW-1];
				end
			end
			tngf_pkg::D_CHK: begin
				ovf_q <= ovf_c;
				rem_q <= x_c[QW+DW-1:QW];
				xl_q  <= x_c[QW-1:0];
				qm_q  <= '0;
				cnt_q <= 5'(QW - 1);
			end
			tngf_pkg::D_RUN: begin
				rem_q <= ge_c ? DW'(r2_c - {1'b0, ad_q}) : r2_c[DW-1:0];
				qm_q  <= {qm_q[QW-2:0], ge_c};
				xl_q  <= {xl_q[QW-2:0], 1'b0};
				cnt_q <= cnt_q - 5'd1;
			end
			tngf_pkg::D_FIN: begin
				quo_q <= res_c;
			end
			default: ;
		endcase
	end

	assign sts.done = done_q;
	assign sts.busy = (st_q != tngf_pkg::D_IDLE);
	assign quo      = quo_q;

endmodule

// File: rtl/core/triangle_tangent_frame_unit.sv
`timescale 1ns / 1ps
// The first and second vertex of a triangle are only held. The third starts
// the sequence to a result: the UV determinant from two products, then for
// each of six components two products and a 32-step divide; a divide is
// cut short when its range check saturates, and all are skipped when the determinant is zero.
// The unit takes no new vertex until the result word has been loaded for output.
// Reset clears the vertex count and the result valid; held vertices are not cleared.
// ----------------------------------------------------------------------------
// triangle_tangent_frame_unit - per-triangle tangent and bitangent
// Holds two vertices, forms deltas on the third and runs the products and
// quotients through one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_unit (
	input  logic       clk,
	input  logic       arst_n,
	tngf_vtx_if.sink   vtx,
	tngf_res_if.source res
);

	localparam int DPW = tngf_pkg::DP_W;
	localparam int UVD = tngf_pkg::DUV_W;
	localparam int DW  = tngf_pkg::DEN_W;
	localparam int QW  = tngf_pkg::QUO_W;

	tngf_pkg::seq_state_t st_q, st_d;

	logic [1:0]                 slot_q;
	logic [1:0]                 ph_q;
	logic [2:0]                 sel_q;

	logic signed [31:0]         hp_q [0:1][0:2];
	logic [15:0]                huv_q [0:1][0:1];
	logic signed [DPW-1:0]      dp1_q [0:2];
	logic signed [DPW-1:0]      dp2_q [0:2];
	logic signed [UVD-1:0]      du1_q, dv1_q, du2_q, dv2_q;
	logic signed [DW-1:0]       det_q;
	logic [QW-1:0]              res_q [0:5];
	logic                       degen_q;

	logic [QW-1:0]              out_q [0:5];
	logic                       out_degen_q;
	logic                       out_valid_q;

	logic                       acc_in;
	logic [1:0]                 slot_eff;
	logic                       load_out;
	logic [2:0]                 jj;
	logic [1:0]                 idx;
	logic                       bit_side;
	logic signed [DPW-1:0]      pos_in [0:2];

	tngf_pkg::mac_ctl_t         mac_ctl;
	logic signed [DPW-1:0]      mac_a;
	logic signed [UVD-1:0]      mac_b;
	logic signed [tngf_pkg::NUM_W-1:0] mac_acc;

	logic                       div_start;
	tngf_pkg::div_sts_t         div_sts;
	logic [QW-1:0]              div_quo;

	assign vtx.ready = (st_q == tngf_pkg::T_IDLE);
	assign acc_in    = vtx.valid && vtx.ready;
	assign slot_eff  = (slot_q == 2'd3) ? 2'd0 : slot_q;
	assign load_out  = (st_q == tngf_pkg::T_DONE) && (!out_valid_q || res.ready);

	assign pos_in[0] = DPW'(vtx.pos_x);
	assign pos_in[1] = DPW'(vtx.pos_y);
	assign pos_in[2] = DPW'(vtx.pos_z);

	// pick the component: tangent xyz first, bitangent xyz after
	assign jj       = sel_q - 3'd1;
	assign bit_side = (jj >= 3'd3);
	assign idx      = bit_side ? 2'(jj - 3'd3) : jj[1:0];

	// operand select for the shared multiplier
	always_comb begin
		mac_ctl.issue = (st_q == tngf_pkg::T_MAC) && (ph_q != 2'd2);
		mac_ctl.sub   = (ph_q == 2'd1);
		if (sel_q == 3'd0) begin
			mac_a = (ph_q == 2'd0) ? DPW'(du1_q) : DPW'(dv1_q);
			mac_b = (ph_q == 2'd0) ? dv2_q : du2_q;
		end else if (!bit_side) begin
			mac_a = (ph_q == 2'd0) ? dp1_q[idx] : dp2_q[idx];
			mac_b = (ph_q == 2'd0) ? dv2_q : dv1_q;
		end else begin
			mac_a = (ph_q == 2'd0) ? dp2_q[idx] : dp1_q[idx];
			mac_b = (ph_q == 2'd0) ? du1_q : du2_q;
		end
	end

	assign div_start = (st_q == tngf_pkg::T_EVAL) && (sel_q != 3'd0);

	// sequencer next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			tngf_pkg::T_IDLE: if (acc_in && slot_eff == 2'd2) st_d = tngf_pkg::T_MAC;
			tngf_pkg::T_MAC:  if (ph_q == 2'd2) st_d = tngf_pkg::T_EVAL;
			tngf_pkg::T_EVAL: begin
				if (sel_q != 3'd0) begin
					st_d = tngf_pkg::T_DIV;
				end else if (mac_acc == '0) begin
					st_d = tngf_pkg::T_DONE;
				end else begin
					st_d = tngf_pkg::T_MAC;
				end
			end
			tngf_pkg::T_DIV: begin
				if (div_sts.done) begin
					st_d = (sel_q == tngf_pkg::NUM_COMP) ? tngf_pkg::T_DONE
						: tngf_pkg::T_MAC;
				end
			end
			tngf_pkg::T_DONE: if (load_out) st_d = tngf_pkg::T_IDLE;
			default:          st_d = tngf_pkg::T_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tngf_pkg::T_IDLE;
			slot_q      <= 2'd0;
			ph_q        <= 2'd0;
			sel_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (acc_in) begin
				slot_q <= (vtx.end_of_mesh || slot_eff == 2'd2) ? 2'd0 : slot_eff + 2'd1;
				sel_q  <= 3'd0;
			end
			if (st_q == tngf_pkg::T_MAC) begin
				ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
			end
			if (st_q == tngf_pkg::T_EVAL && sel_q == 3'd0) begin
				sel_q <= 3'd1;
			end
			if (st_q == tngf_pkg::T_DIV && div_sts.done && sel_q != tngf_pkg::NUM_COMP) begin
				sel_q <= sel_q + 3'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold vertices, form deltas, collect results
	always_ff @(posedge clk) begin
		if (acc_in) begin
			if (slot_eff != 2'd2) begin
				hp_q[slot_eff[0]][0]  <= vtx.pos_x;
				hp_q[slot_eff[0]][1]  <= vtx.pos_y;
				hp_q[slot_eff[0]][2]  <= vtx.pos_z;
				huv_q[slot_eff[0]][0] <= vtx.tex_u;
				huv_q[slot_eff[0]][1] <= vtx.tex_v;
			end else begin
				for (int k = 0; k < 3; k++) begin
					dp1_q[k] <= DPW'(hp_q[1][k]) - DPW'(hp_q[0][k]);
					dp2_q[k] <= pos_in[k] - DPW'(hp_q[0][k]);
				end
				du1_q <= {1'b0, huv_q[1][0]} - {1'b0, huv_q[0][0]};
				dv1_q <= {1'b0, huv_q[1][1]} - {1'b0, huv_q[0][1]};
				du2_q <= {1'b0, vtx.tex_u} - {1'b0, huv_q[0][0]};
				dv2_q <= {1'b0, vtx.tex_v} - {1'b0, huv_q[0][1]};
			end
		end
		if (st_q == tngf_pkg::T_EVAL && sel_q == 3'd0) begin
			det_q   <= DW'(mac_acc);
			degen_q <= (mac_acc == '0);
			if (mac_acc == '0) begin
				for (int k = 0; k < 6; k++) begin
					res_q[k] <= '0;
				end
			end
		end
		if (st_q == tngf_pkg::T_DIV && div_sts.done) begin
			res_q[jj] <= div_quo;
		end
		if (load_out) begin
			out_q       <= res_q;
			out_degen_q <= degen_q;
		end
	end

	tngf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (mac_acc)
	);

	tngf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mac_acc),
		.den    (det_q),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	// drive the result word
	assign res.valid       = out_valid_q;
	assign res.tangent_x   = out_q[0];
	assign res.tangent_y   = out_q[1];
	assign res.tangent_z   = out_q[2];
	assign res.bitangent_x = out_q[3];
	assign res.bitangent_y = out_q[4];
	assign res.bitangent_z = out_q[5];
	assign res.degenerate  = out_degen_q;

endmodule

// File: rtl/core/tngf_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tngf_check - port-level checks for the tangent frame unit
// Watches the vertex and result channels and the degenerate encoding.
// ----------------------------------------------------------------------------
module tngf_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_degenerate,
	input logic [31:0] tx,
	input logic [31:0] ty,
	input logic [31:0] tz,
	input logic [31:0] bx,
	input logic [31:0] by,
	input logic [31:0] bz
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx) && $stable(bz))
		else $error("result word dropped or changed while stalled");

	// degenerate results carry zero vectors
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_degenerate |-> tx == 32'd0 && ty == 32'd0 && tz == 32'd0
			&& bx == 32'd0 && by == 32'd0 && bz == 32'd0)
		else $error("degenerate result with nonzero vector");

	// a new result only follows a busy cycle
	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while vertex port was idle");

	// the sequencer is idle again when a result word appears
	a_rose_busy2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("sequencer did not return to idle after result");

endmodule

bind triangle_tangent_frame_unit tngf_check u_tngf_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (vtx.ready),
	.out_valid      (res.valid),
	.out_ready      (res.ready),
	.out_degenerate (res.degenerate),
	.tx             (res.tangent_x),
	.ty             (res.tangent_y),
	.tz             (res.tangent_z),
	.bx             (res.bitangent_x),
	.by             (res.bitangent_y),
	.bz             (res.bitangent_z)
);

// File: dv/tngf_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tngf_frame_checker - tangent frame predictor and result scoreboard
// Watches the vertex and result channels, predicts one tangent/bitangent
// word per completed triangle and compares each result field by field.
// ----------------------------------------------------------------------------
module tngf_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	tngf_vtx_if.sink   vtx,
	tngf_res_if.sink   res,
	output int         fail_cnt,
	output int         frame_cnt,
	output int         flat_cnt,
	output int         pending
);

	typedef struct packed {
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic               degenerate;
	} frame_t;

	frame_t             frame_q[$];
	logic signed [31:0] corner_pos[2][3];
	logic [15:0]        corner_uv[2][2];
	logic [1:0]         corner_cnt;

	assign pending = frame_q.size();

	// scale n by the UV fraction, divide by d toward zero, clamp to 32 bits
	function automatic logic signed [31:0] scaled_div(longint n, longint d);
		longint q, r, t;
		q = n / d;
		r = n % d;
		if (q > 64'sd4294967296) return tngf_pkg::SAT_POS;
		if (q < -64'sd4294967296) return tngf_pkg::SAT_NEG;
		t = q * (64'sd1 <<< tngf_pkg::UV_SHIFT)
			+ (r * (64'sd1 <<< tngf_pkg::UV_SHIFT)) / d;
		if (t > 64'sd2147483647) return tngf_pkg::SAT_POS;
		if (t < -64'sd2147483648) return tngf_pkg::SAT_NEG;
		return t[31:0];
	endfunction

	function automatic frame_t solve_frame(logic signed [31:0] p[3], logic [15:0] u,
			logic [15:0] v);
		frame_t f;
		longint dp1[3], dp2[3];
		longint du1, dv1, du2, dv2, det;
		logic signed [31:0] t[3], b[3];
		du1 = longint'(corner_uv[1][0]) - longint'(corner_uv[0][0]);
		dv1 = longint'(corner_uv[1][1]) - longint'(corner_uv[0][1]);
		du2 = longint'(u) - longint'(corner_uv[0][0]);
		dv2 = longint'(v) - longint'(corner_uv[0][1]);
		det = du1 * dv2 - dv1 * du2;
		f = '0;
		if (det == 0) begin
			f.degenerate = 1'b1;
			return f;
		end
		for (int k = 0; k < 3; k++) begin
			dp1[k] = longint'(corner_pos[1][k]) - longint'(corner_pos[0][k]);
			dp2[k] = longint'(p[k]) - longint'(corner_pos[0][k]);
			t[k] = scaled_div(dp1[k] * dv2 - dp2[k] * dv1, det);
			b[k] = scaled_div(dp2[k] * du1 - dp1[k] * du2, det);
		end
		f.tx = t[0]; f.ty = t[1]; f.tz = t[2];
		f.bx = b[0]; f.by = b[1]; f.bz = b[2];
		return f;
	endfunction

	// predict on each accepted vertex, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] p[3];
		frame_t exp_f, got;
		if (!arst_n) begin
			corner_cnt <= '0;
			fail_cnt   <= 0;
			frame_cnt  <= 0;
			flat_cnt   <= 0;
		end else begin
			if (vtx.valid && vtx.ready) begin
				p[0] = vtx.pos_x; p[1] = vtx.pos_y; p[2] = vtx.pos_z;
				if (corner_cnt < 2) begin
					for (int k = 0; k < 3; k++) corner_pos[corner_cnt][k] = p[k];
					corner_uv[corner_cnt][0] = vtx.tex_u;
					corner_uv[corner_cnt][1] = vtx.tex_v;
					corner_cnt <= vtx.end_of_mesh ? 2'd0 : corner_cnt + 2'd1;
				end else begin
					exp_f = solve_frame(p, vtx.tex_u, vtx.tex_v);
					frame_q.push_back(exp_f);
					corner_cnt <= 2'd0;
				end
			end
			if (res.valid && res.ready) begin
				got = '{res.tangent_x, res.tangent_y, res.tangent_z, res.bitangent_x,
					res.bitangent_y, res.bitangent_z, res.degenerate};
				frame_cnt <= frame_cnt + 1;
				if (got.degenerate) flat_cnt <= flat_cnt + 1;
				if (frame_q.size() == 0) begin
					fail_cnt <= fail_cnt + 1;
					if (fail_cnt < 10) $display("unexpected result word %h", got);
				end else begin
					exp_f = frame_q.pop_front();
					if (got !== exp_f) begin
						fail_cnt <= fail_cnt + 1;
						if (fail_cnt < 10)
							$display("mismatch T exp %h %h %h got %h %h %h",
								exp_f.tx, exp_f.ty, exp_f.tz, got.tx, got.ty, got.tz);
						if (fail_cnt < 10)
							$display("         B exp %h %h %h got %h %h %h deg %b/%b",
								exp_f.bx, exp_f.by, exp_f.bz, got.bx, got.by, got.bz,
								exp_f.degenerate, got.degenerate);
					end
				end
			end
		end
	end

endmodule

// File: dv/tb_triangle_tangent_frame_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_tangent_frame_unit - vertex stream regression
// Feeds directed and random triangles, with mesh ends and broken triangles,
// under three idle patterns; the checker predicts and scores the results.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_frame_unit;

	localparam int WDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   fail_cnt, frame_cnt, flat_cnt, pending;
	int   send_idle, recv_idle;
	int   wdog;
	int   sent;

	tngf_vtx_if vtx ();
	tngf_res_if res ();

	triangle_tangent_frame_unit dut (.clk(clk), .arst_n(arst_n), .vtx(vtx), .res(res));

	tngf_frame_checker u_chk (.clk(clk), .arst_n(arst_n), .vtx(vtx), .res(res),
		.fail_cnt(fail_cnt), .frame_cnt(frame_cnt), .flat_cnt(flat_cnt), .pending(pending));

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// stall the result side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) res.ready <= 1'b0;
		else res.ready <= ($urandom_range(99) >= recv_idle);
	end

	// end the run when nothing moves for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wdog <= 0;
		end else if ((vtx.valid && vtx.ready) || (res.valid && res.ready)) begin
			wdog <= 0;
		end else begin
			wdog <= wdog + 1;
			if (wdog == WDOG_LIMIT) begin
				$display("watchdog expired, %0d results pending", pending);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_uv();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	// send one vertex word, holding valid until accepted; valid stays up until
	// an idle wait of the next word or drain() drops it
	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [15:0] u, logic [15:0] v, logic eom);
		while ($urandom_range(99) < send_idle) begin
			vtx.valid <= 1'b0;
			@(posedge clk);
		end
		vtx.valid <= 1'b1;
		vtx.pos_x <= x; vtx.pos_y <= y; vtx.pos_z <= z;
		vtx.tex_u <= u; vtx.tex_v <= v; vtx.end_of_mesh <= eom;
		do @(posedge clk); while (!vtx.ready);
		sent++;
	endtask

	task automatic send_rand_vertex(logic eom);
		send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_uv(), rand_uv(), eom);
	endtask

	// drop valid and wait until every predicted result has come back
	task automatic drain();
		vtx.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int n;
		vtx.valid = 1'b0;
		vtx.pos_x = '0; vtx.pos_y = '0; vtx.pos_z = '0;
		vtx.tex_u = '0; vtx.tex_v = '0; vtx.end_of_mesh = 1'b0;
		sent = 0;
		send_idle = 19;
		recv_idle = 70;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit right triangle: plain tangent along x, bitangent along y
		send_vertex(0, 0, 0, 0, 0, 0);
		send_vertex(32'h0001_0000, 0, 0, 16'h8000, 0, 0);
		send_vertex(0, 32'h0001_0000, 0, 0, 16'h8000, 0);
		// zero determinant: all UVs equal
		send_vertex(5, 6, 7, 100, 100, 0);
		send_vertex(8, 9, 10, 100, 100, 0);
		send_vertex(1, 2, 3, 100, 100, 0);
		// saturation: full-scale positions over a one-step UV span
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 0);
		// extreme UV corners
		send_vertex(1000, -1000, 0, 16'hFFFF, 16'hFFFF, 0);
		send_vertex(-1000, 1000, 0, 0, 16'hFFFF, 0);
		send_vertex(0, 0, 1000, 16'hFFFF, 0, 1);
		// mesh end after one and after two vertices drops the partial triangle
		send_vertex(1, 1, 1, 1, 1, 1);
		send_vertex(2, 2, 2, 2, 2, 0);
		send_vertex(3, 3, 3, 3, 3, 1);
		// mesh end on the third vertex, then a fresh triangle
		send_vertex(0, 0, 0, 0, 0, 0);
		send_vertex(32'hFFFF_0000, 7, 9, 16'h0100, 16'h0003, 0);
		send_vertex(11, 32'hFFFF_FFF0, 4, 16'h0007, 16'h0200, 1);
		// hold off until every result has come back
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 19 : (phase == 1) ? 70 : 0;
			recv_idle = (phase == 0) ? 70 : (phase == 1) ? 19 : 0;
			n = 0;
			while (n < 310) begin
				if ($urandom_range(9) == 0) begin
					// broken triangle ending the mesh early
					repeat ($urandom_range(1)) begin
						send_rand_vertex(1'b0);
						n++;
					end
					send_rand_vertex(1'b1);
					n++;
				end else begin
					send_rand_vertex(1'b0);
					send_rand_vertex(1'b0);
					send_rand_vertex($urandom_range(3) == 0);
					n += 3;
				end
			end
			drain();
		end

		drain();
		repeat (300) @(posedge clk);
		$display("Sent %0d vertex words; checked %0d frames, %0d degenerate.",
			sent, frame_cnt, flat_cnt);
		if (fail_cnt == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
